/* sv/acf_pkg.sv */
// Shared types, character codes and command text tables for the AT command formatter.
package acf_pkg;

	localparam logic [3:0] ACT_RATE     = 4'd0;
	localparam logic [3:0] ACT_MODE     = 4'd1;
	localparam logic [3:0] ACT_WAKE     = 4'd2;
	localparam logic [3:0] ACT_ADDR     = 4'd3;
	localparam logic [3:0] ACT_PREAMBLE = 4'd4;
	localparam logic [3:0] ACT_BW       = 4'd5;
	localparam logic [3:0] ACT_FREQ     = 4'd6;
	localparam logic [3:0] ACT_SF       = 4'd7;
	localparam logic [3:0] ACT_SAVE     = 4'd8;
	localparam logic [3:0] ACT_QUERY    = 4'd9;
	localparam logic [3:0] ACT_POWER    = 4'd10;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;

	localparam int ARG_MAX     = 5;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [3:0]  action;
		logic [15:0] value;
	} acf_in_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last;
	} acf_out_t;

	// One formatted command: fixed prefix and suffix come from the action,
	// the argument bytes are filled in by the front end.
	typedef struct packed {
		logic [3:0]                 action;
		logic [ARG_MAX-1:0][7:0]    arg;
		logic [2:0]                 arg_len;
	} acf_desc_t;

	// Prefix text, right aligned: byte k of a prefix of length L sits at 8*(L-1-k).
	function automatic logic [127:0] pre_text(input logic [3:0] action);
		logic [127:0] t;
		t = '0;
		case (action)
			ACT_RATE:     t = 128'("AT+UART=");
			ACT_MODE:     t = 128'("AT+MODE=");
			ACT_WAKE:     t = 128'("AT+WT=");
			ACT_ADDR:     t = 128'("AT+ADR=");
			ACT_PREAMBLE: t = 128'("AT+PB=");
			ACT_BW:       t = 128'("AT+BW=");
			ACT_FREQ:     t = 128'("AT+FEQ=434000000");
			ACT_SF:       t = 128'("AT+SF=");
			ACT_SAVE:     t = 128'("ATW");
			ACT_QUERY:    t = 128'("ATL");
			ACT_POWER:    t = 128'("AT+PWR=29");
			default:      t = '0;
		endcase
		return t;
	endfunction

	function automatic logic [4:0] pre_len(input logic [3:0] action);
		logic [4:0] n;
		n = '0;
		case (action)
			ACT_RATE:     n = 5'd8;
			ACT_MODE:     n = 5'd8;
			ACT_WAKE:     n = 5'd6;
			ACT_ADDR:     n = 5'd7;
			ACT_PREAMBLE: n = 5'd6;
			ACT_BW:       n = 5'd6;
			ACT_FREQ:     n = 5'd16;
			ACT_SF:       n = 5'd6;
			ACT_SAVE:     n = 5'd3;
			ACT_QUERY:    n = 5'd3;
			ACT_POWER:    n = 5'd9;
			default:      n = '0;
		endcase
		return n;
	endfunction

	function automatic logic [23:0] post_text(input logic [3:0] action);
		logic [23:0] t;
		t = '0;
		case (action)
			ACT_RATE:     t = 24'(",0");
			ACT_PREAMBLE: t = 24'("000");
			default:      t = '0;
		endcase
		return t;
	endfunction

	function automatic logic [1:0] post_len(input logic [3:0] action);
		logic [1:0] n;
		n = '0;
		case (action)
			ACT_RATE:     n = 2'd2;
			ACT_PREAMBLE: n = 2'd3;
			default:      n = '0;
		endcase
		return n;
	endfunction

endpackage

/* sv/acf_front.sv */
// Front end: accepts commands, drops invalid ones, converts the address to decimal.
module acf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  acf_pkg::acf_in_t   cmd,
	output logic               q_push,
	input  logic               q_full,
	output acf_pkg::acf_desc_t q_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHIFT = 2'd1;
	localparam logic [1:0] ST_FMT   = 2'd2;

	logic [1:0]         state_q;
	logic [3:0]         cnt_q;
	logic [15:0]        bin_q;
	logic [19:0]        bcd_q;
	logic               desc_valid_q;
	acf_pkg::acf_desc_t desc_q;

	logic               accept;
	logic               desc_take;
	logic               desc_set;
	logic [7:0]         d;
	logic               imm_emit;
	logic               is_addr;
	acf_pkg::acf_desc_t imm_desc;
	acf_pkg::acf_desc_t adr_desc;
	logic [19:0]        bcd_adj;
	logic [2:0]         nd;

	assign full      = (state_q != ST_IDLE) || (desc_valid_q && q_full);
	assign accept    = push && !full;
	assign desc_take = desc_valid_q && !q_full;
	assign q_push    = desc_take;
	assign q_data    = desc_q;
	assign d         = cmd.value[7:0];
	assign is_addr   = (cmd.action == acf_pkg::ACT_ADDR);
	// accept implies the idle state
	assign desc_set  = (accept && !is_addr && imm_emit) || (state_q == ST_FMT);

	// classify and build the descriptor of every command but the address
	always_comb begin
		imm_desc         = '0;
		imm_desc.action  = cmd.action;
		imm_desc.arg[0]  = 8'(acf_pkg::CH_ZERO + d);
		imm_desc.arg_len = 3'd1;
		imm_emit         = 1'b1;
		unique case (cmd.action)
			acf_pkg::ACT_RATE, acf_pkg::ACT_WAKE, acf_pkg::ACT_PREAMBLE,
			acf_pkg::ACT_BW: begin
			end
			acf_pkg::ACT_MODE: begin
				imm_emit = (d <= 8'd1);
			end
			acf_pkg::ACT_SF: begin
				if (d >= 8'd10 && d <= 8'd12) begin
					imm_desc.arg[0]  = acf_pkg::CH_ONE;
					imm_desc.arg[1]  = 8'(acf_pkg::CH_ZERO + d - 8'd10);
					imm_desc.arg_len = 3'd2;
				end else begin
					imm_emit = (d >= 8'd7 && d <= 8'd9);
				end
			end
			acf_pkg::ACT_FREQ, acf_pkg::ACT_SAVE, acf_pkg::ACT_QUERY,
			acf_pkg::ACT_POWER: begin
				imm_desc.arg_len = 3'd0;
			end
			default: begin
				// address is handled by the converter, the rest is unknown
				imm_emit = 1'b0;
			end
		endcase
	end

	// shift-add-3 correction of each BCD digit before the shift
	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < 5; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				bcd_adj[4*i +: 4] = 4'(bcd_q[4*i +: 4] + 4'd3);
		end
	end

	// leading zero suppression; zero still shows one digit
	always_comb begin
		if (bcd_q[19:16] != 4'd0)
			nd = 3'd5;
		else if (bcd_q[15:12] != 4'd0)
			nd = 3'd4;
		else if (bcd_q[11:8] != 4'd0)
			nd = 3'd3;
		else if (bcd_q[7:4] != 4'd0)
			nd = 3'd2;
		else
			nd = 3'd1;
		adr_desc         = '0;
		adr_desc.action  = acf_pkg::ACT_ADDR;
		adr_desc.arg_len = nd;
		for (int k = 0; k < acf_pkg::ARG_MAX; k++) begin
			if (3'(k) < nd)
				adr_desc.arg[k] = {4'h3, bcd_q[4*(3'(nd - 3'd1 - 3'(k))) +: 4]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			desc_valid_q <= 1'b0;
		end else begin
			if (desc_set)
				desc_valid_q <= 1'b1;
			else if (desc_take)
				desc_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_addr) begin
						state_q <= ST_SHIFT;
						cnt_q   <= '0;
					end
				end
				ST_SHIFT: begin
					cnt_q <= 4'(cnt_q + 4'd1);
					if (cnt_q == 4'd15)
						state_q <= ST_FMT;
				end
				ST_FMT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			bin_q  <= cmd.value;
			bcd_q  <= '0;
			desc_q <= imm_desc;
		end else if (state_q == ST_SHIFT) begin
			{bcd_q, bin_q} <= {bcd_adj[18:0], bin_q, 1'b0};
		end else if (state_q == ST_FMT) begin
			desc_q <= adr_desc;
		end
	end

endmodule

/* sv/acf_fifo.sv */
// Short descriptor queue between the front end and the byte sequencer.
module acf_fifo #(
	parameter int DEPTH = acf_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  acf_pkg::acf_desc_t wdata,
	input  logic               pop,
	output logic               empty,
	output acf_pkg::acf_desc_t rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	acf_pkg::acf_desc_t mem_q [DEPTH];
	logic [PW-1:0]      wr_q;
	logic [PW-1:0]      rd_q;
	logic [CW-1:0]      cnt_q;

	logic do_push;
	logic do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
			if (do_pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
			if (do_push && !do_pop)
				cnt_q <= CW'(cnt_q + 1'b1);
			else if (do_pop && !do_push)
				cnt_q <= CW'(cnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end

endmodule

/* sv/acf_back.sv */
// Back end: walks one command descriptor and emits its bytes into the output register.
module acf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	output logic               q_pop,
	input  acf_pkg::acf_desc_t q_head,
	output logic               empty,
	input  logic               pop,
	output acf_pkg::acf_out_t  rsp
);

	acf_pkg::acf_desc_t cur_q;
	logic               cur_valid_q;
	logic [4:0]         idx_q;
	logic               out_valid_q;
	acf_pkg::acf_out_t  rsp_q;

	logic [4:0]         pl;
	logic [1:0]         po;
	logic [4:0]         e1;
	logic [4:0]         e2;
	logic [3:0]         pre_pos;
	logic [1:0]         post_pos;
	logic [2:0]         arg_pos;
	logic [127:0]       pre_t;
	logic [23:0]        post_t;
	acf_pkg::acf_out_t  gen;
	logic               step;
	logic               fin;
	logic               load;

	assign pl       = acf_pkg::pre_len(cur_q.action);
	assign po       = acf_pkg::post_len(cur_q.action);
	assign pre_t    = acf_pkg::pre_text(cur_q.action);
	assign post_t   = acf_pkg::post_text(cur_q.action);
	assign e1       = 5'(pl + 5'(cur_q.arg_len));
	assign e2       = 5'(e1 + 5'(po));
	assign pre_pos  = 4'(pl - 5'd1 - idx_q);
	assign arg_pos  = 3'(idx_q - pl);
	assign post_pos = 2'(e2 - 5'd1 - idx_q);

	// byte at idx: prefix, argument, suffix, CR, LF
	always_comb begin
		gen.last = 1'b0;
		if (idx_q < pl)
			gen.char_out = pre_t[{pre_pos, 3'b000} +: 8];
		else if (idx_q < e1)
			gen.char_out = cur_q.arg[arg_pos];
		else if (idx_q < e2)
			gen.char_out = post_t[{post_pos, 3'b000} +: 8];
		else if (idx_q == e2)
			gen.char_out = acf_pkg::CH_CR;
		else begin
			gen.char_out = acf_pkg::CH_LF;
			gen.last     = 1'b1;
		end
	end

	assign step  = cur_valid_q && (!out_valid_q || pop);
	assign fin   = step && gen.last;
	assign load  = (!cur_valid_q || fin) && !q_empty;
	assign q_pop = load;
	assign empty = !out_valid_q;
	assign rsp   = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (fin) begin
				cur_valid_q <= 1'b0;
			end else if (step) begin
				idx_q <= 5'(idx_q + 5'd1);
			end
			if (step)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			cur_q <= q_head;
		if (step)
			rsp_q <= gen;
	end

endmodule

/* sv/at_command_formatter_core.sv */
// Top level of the AT command formatter: front end, descriptor queue, byte sequencer.
//
// Usage:
//   Command side is a queue write port: drive cmd and raise push; the word is
//   taken on a clock edge with push high and full low.
//   Result side is a queue read port: while empty is low, rsp holds the next
//   byte of the command line; it is taken on an edge with pop high.
//   rsp.last marks the closing LF of each line.
// Path: the first byte of a line passes the front end descriptor register,
//   the descriptor queue, the back end descriptor register and the output
//   register; address commands first run the binary to decimal conversion
//   (16 shift-add-3 steps and one formatting step).
// Throughput: one byte per cycle while pop is high and lines are queued; a line
//   is 5 to 18 bytes long, and the address converter takes no new command until done.
// Invalid commands (bad mode, bad spreading factor, unknown action) are taken
//   and produce no bytes.
// Reset clears all queues; no word is pending afterwards. When pop is held
//   low, the output register holds its byte and the queue then full back-
//   pressures the command side.
module at_command_formatter_core #(
	parameter int QDEPTH = acf_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  acf_pkg::acf_in_t  cmd,
	output logic              empty,
	input  logic              pop,
	output acf_pkg::acf_out_t rsp
);

	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_empty;
	acf_pkg::acf_desc_t q_wdata;
	acf_pkg::acf_desc_t q_rdata;

	acf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.cmd    (cmd),
		.q_push (q_push),
		.q_full (q_full),
		.q_data (q_wdata)
	);

	acf_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	acf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_head  (q_rdata),
		.empty   (empty),
		.pop     (pop),
		.rsp     (rsp)
	);

	// an accepted address command holds off the next word while converting
	a_addr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && cmd.action == acf_pkg::ACT_ADDR |=> full)
		else $error("address conversion did not block the command port");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("descriptor pushed into a full queue");

	a_last_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.last |-> rsp.char_out == acf_pkg::CH_LF)
		else $error("last flag on a byte other than LF");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("descriptor popped from an empty queue");

endmodule

/* bench/at_command_formatter_core_test.sv */
// Self-checking testbench for the AT command formatter core: predicted byte stream vs. DUT.
`timescale 1ns / 100ps

module at_command_formatter_core_test;

	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 40;
	localparam int PRINT_LIMIT = 40;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	acf_pkg::acf_in_t   cmd;
	logic               empty;
	logic               pop;
	acf_pkg::acf_out_t  rsp;

	acf_pkg::acf_out_t expected_bytes[$];
	logic [7:0]        line_buf[$];
	int                error_count = 0;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	int                hold_off_left = 0;
	int                quiet_cycles = 0;

	at_command_formatter_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.cmd    (cmd),
		.empty  (empty),
		.pop    (pop),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (error_count < PRINT_LIMIT)
			$display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic void add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endfunction

	// Builds the command line for one word and queues its bytes.
	function automatic void format_line(input acf_pkg::acf_in_t c);
		logic [7:0]  d;
		logic [7:0]  digits[$];
		int unsigned v;
		bit          emit;
		int          i;
		d = c.value[7:0];
		emit = 1'b1;
		line_buf.delete();
		case (c.action)
			acf_pkg::ACT_RATE: begin
				add_text("AT+UART=");
				line_buf.push_back(acf_pkg::CH_ZERO + d);
				add_text(",0");
			end
			acf_pkg::ACT_MODE: begin
				if (d > 8'd1) begin
					emit = 1'b0;
				end else begin
					add_text("AT+MODE=");
					line_buf.push_back(acf_pkg::CH_ZERO + d);
				end
			end
			acf_pkg::ACT_WAKE: begin
				add_text("AT+WT=");
				line_buf.push_back(acf_pkg::CH_ZERO + d);
			end
			acf_pkg::ACT_ADDR: begin
				add_text("AT+ADR=");
				v = 32'(c.value);
				if (v == 0) begin
					line_buf.push_back(acf_pkg::CH_ZERO);
				end else begin
					while (v > 0) begin
						digits.push_front(acf_pkg::CH_ZERO + 8'(v % 10));
						v = v / 10;
					end
					foreach (digits[k])
						line_buf.push_back(digits[k]);
				end
			end
			acf_pkg::ACT_PREAMBLE: begin
				add_text("AT+PB=");
				line_buf.push_back(acf_pkg::CH_ZERO + d);
				add_text("000");
			end
			acf_pkg::ACT_BW: begin
				add_text("AT+BW=");
				line_buf.push_back(acf_pkg::CH_ZERO + d);
			end
			acf_pkg::ACT_FREQ: add_text("AT+FEQ=434000000");
			acf_pkg::ACT_SF: begin
				if (d >= 8'd7 && d <= 8'd9) begin
					add_text("AT+SF=");
					line_buf.push_back(acf_pkg::CH_ZERO + d);
				end else if (d >= 8'd10 && d <= 8'd12) begin
					add_text("AT+SF=1");
					line_buf.push_back(acf_pkg::CH_ZERO + (d - 8'd10));
				end else begin
					emit = 1'b0;
				end
			end
			acf_pkg::ACT_SAVE:  add_text("ATW");
			acf_pkg::ACT_QUERY: add_text("ATL");
			acf_pkg::ACT_POWER: add_text("AT+PWR=29");
			default:            emit = 1'b0;
		endcase
		if (emit) begin
			line_buf.push_back(acf_pkg::CH_CR);
			line_buf.push_back(acf_pkg::CH_LF);
			for (i = 0; i < line_buf.size(); i++)
				expected_bytes.push_back('{char_out: line_buf[i],
					last: (i == line_buf.size() - 1)});
		end
	endfunction

	// Result check first, then prediction of the word taken on this edge.
	always @(posedge clk) begin
		acf_pkg::acf_out_t want;
		if (pop && !empty) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected byte", int'(rsp.char_out), 0);
			end else begin
				want = expected_bytes.pop_front();
				if (rsp.char_out !== want.char_out)
					report_mismatch("char_out", int'(rsp.char_out), int'(want.char_out));
				if (rsp.last !== want.last)
					report_mismatch("last", int'(rsp.last), int'(want.last));
			end
		end
		if (arst_n && push && !full)
			format_line(cmd);
	end

	// Receiver: long hold-off on request, random idling otherwise.
	always @(posedge clk) begin
		if (hold_off_left > 0) begin
			pop <= 1'b0;
			hold_off_left = hold_off_left - 1;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Leaves push high on return; the next call or the caller lowers it.
	task automatic send_cmd(input acf_pkg::acf_in_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		cmd  <= c;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_word(input logic [3:0] act, input logic [15:0] val);
		send_cmd('{action: act, value: val});
	endtask

	// the first wait lets the prediction of the last word reach the queue
	task automatic wait_drain();
		@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed commands, some noise: unknown actions, bad mode / SF.
	function automatic acf_pkg::acf_in_t random_cmd();
		acf_pkg::acf_in_t c;
		int               n;
		c.value = 16'($urandom);
		if ($urandom_range(99) < 10) begin
			c.action = 4'($urandom_range(15));
			return c;
		end
		c.action = 4'($urandom_range(acf_pkg::ACT_POWER));
		case (c.action)
			acf_pkg::ACT_MODE: c.value[7:0] = 8'($urandom_range(1));
			acf_pkg::ACT_SF:   c.value[7:0] = 8'($urandom_range(12, 7));
			acf_pkg::ACT_ADDR: begin
				n = $urandom_range(16, 1);
				c.value = c.value & 16'((32'd1 << n) - 1);
			end
			default: begin
				if ($urandom_range(99) < 70)
					c.value[7:0] = 8'($urandom_range(9));
			end
		endcase
		return c;
	endfunction

	task automatic run_random(input int count, input int s_pct, input int r_pct);
		int i;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (i = 0; i < count; i++)
			send_cmd(random_cmd());
		push <= 1'b0;
		wait_drain();
	endtask

	task automatic test_directed();
		send_idle_pct = 14;
		recv_idle_pct = 67;
		send_word(acf_pkg::ACT_RATE, 16'h0000);
		send_word(acf_pkg::ACT_RATE, 16'hFFFF);     // digit wraps, upper byte ignored
		send_word(acf_pkg::ACT_MODE, 16'h0000);
		send_word(acf_pkg::ACT_MODE, 16'h0001);
		send_word(acf_pkg::ACT_MODE, 16'h0002);     // bad mode, no line
		send_word(acf_pkg::ACT_MODE, 16'hFF00);
		send_word(acf_pkg::ACT_WAKE, 16'h0009);
		send_word(acf_pkg::ACT_ADDR, 16'h0000);
		send_word(acf_pkg::ACT_ADDR, 16'd9);
		send_word(acf_pkg::ACT_ADDR, 16'd10);
		send_word(acf_pkg::ACT_ADDR, 16'd10000);
		send_word(acf_pkg::ACT_ADDR, 16'hFFFF);
		send_word(acf_pkg::ACT_PREAMBLE, 16'h0003);
		send_word(acf_pkg::ACT_BW, 16'h00FF);
		send_word(acf_pkg::ACT_FREQ, 16'hABCD);
		send_word(acf_pkg::ACT_SF, 16'd6);
		send_word(acf_pkg::ACT_SF, 16'd7);
		send_word(acf_pkg::ACT_SF, 16'd9);
		send_word(acf_pkg::ACT_SF, 16'd10);
		send_word(acf_pkg::ACT_SF, 16'h550C);
		send_word(acf_pkg::ACT_SF, 16'd13);
		send_word(acf_pkg::ACT_SAVE, 16'h0000);
		send_word(acf_pkg::ACT_QUERY, 16'hFFFF);
		send_word(acf_pkg::ACT_POWER, 16'h1234);
		send_word(4'd11, 16'h0001);
		send_word(4'd15, 16'hFFFF);
		push <= 1'b0;
		wait_drain();
	endtask

	task automatic test_slow_receiver();
		run_random(100, 14, 67);
	endtask

	task automatic test_slow_sender();
		run_random(100, 67, 14);
	endtask

	task automatic test_full_rate();
		run_random(100, 0, 0);
	endtask

	task automatic test_backpressure();
		int i;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_left = 250;
		for (i = 0; i < 14; i++)
			send_cmd(random_cmd());
		push <= 1'b0;
		wait_drain();
	endtask

	task automatic test_drain_pause();
		int i;
		send_idle_pct = 14;
		recv_idle_pct = 14;
		for (i = 0; i < 6; i++)
			send_cmd(random_cmd());
		push <= 1'b0;
		wait_drain();
		for (i = 0; i < 6; i++)
			send_cmd(random_cmd());
		push <= 1'b0;
		wait_drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		push   <= 1'b0;
		pop    <= 1'b0;
		cmd    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_slow_receiver();
		test_slow_sender();
		test_full_rate();
		test_backpressure();
		test_drain_pause();

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_bytes.size() != 0)
			report_mismatch("bytes never delivered", 0, expected_bytes.size());
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
